FILE: design/hsd_pkg.sv
package hsd_pkg;

	localparam int TIME_BITS = 32;

	localparam logic [1:0] FUNC_SAMPLE     = 2'd0;
	localparam logic [1:0] FUNC_ZERO_STEPS = 2'd1;
	localparam logic [1:0] FUNC_CLEAR      = 2'd2;

	localparam logic [2:0] HALL_NONE    = 3'd0;
	localparam logic [2:0] HALL_INVALID = 3'd7;

	localparam logic signed [1:0] DIR_NONE = 2'sd0;
	localparam logic signed [1:0] DIR_POS  = 2'sd1;
	localparam logic signed [1:0] DIR_NEG  = -2'sd1;

	localparam logic [15:0] ERR_MAX = 16'hFFFF;

	// successor of a hall code in the positive commutation order 1-3-2-6-4-5
	function automatic logic [2:0] next_positive(input logic [2:0] code);
		logic [2:0] nxt;
		unique case (code)
			3'd1: nxt = 3'd3;
			3'd2: nxt = 3'd6;
			3'd3: nxt = 3'd2;
			3'd4: nxt = 3'd5;
			3'd5: nxt = 3'd1;
			3'd6: nxt = 3'd4;
			default: nxt = HALL_NONE;
		endcase
		return nxt;
	endfunction

	function automatic logic code_valid(input logic [2:0] code);
		return (code != HALL_NONE) && (code != HALL_INVALID);
	endfunction

endpackage

FILE: design/hsd_ram.sv
module hsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/hall_step_decoder_with_period_window.sv
// channel | direction | handshake           | payload
// in      | to block  | in_valid / in_ready | func, hall_code, timestamp
// out     | from block| out_valid/out_ready | active_code, step_count, direction,
//         |           |                     | error_count, interval_sum,
//         |           |                     | intervals_held, step_seen, error_seen
//
// One beat per cycle sustained while out_ready is high; the result beat passes through
// the input register, then the result register. The interval ring is a RAM whose
// registered read is issued ahead for the next write slot.
// Reset clears all control state at once; the ring needs no clearing pass.
// A stalled output holds the result register and the input register; in_ready
// drops only when both are full and out_ready is low.
module hall_step_decoder_with_period_window #(
	parameter int WINDOW = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          func,
	input  logic [2:0]                          hall_code,
	input  logic [31:0]                         timestamp,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          active_code,
	output logic [31:0]                         step_count,
	output logic signed [1:0]                   direction,
	output logic [15:0]                         error_count,
	output logic [hsd_pkg::TIME_BITS+$clog2(WINDOW)-1:0] interval_sum,
	output logic [$clog2(WINDOW+1)-1:0]         intervals_held,
	output logic                                step_seen,
	output logic                                error_seen
);

	localparam int TW     = hsd_pkg::TIME_BITS;
	localparam int IDX_W  = $clog2(WINDOW);
	localparam int HELD_W = $clog2(WINDOW + 1);
	localparam int SUM_W  = TW + IDX_W;

	logic              valid_s1;
	logic [1:0]        func_s1;
	logic [2:0]        code_s1;
	logic [TW-1:0]     ts_s1;
	logic              advance;
	logic              fire;

	logic [2:0]        hall_q, hall_d;
	logic [31:0]       steps_q, steps_d;
	logic signed [1:0] dir_q, dir_d;
	logic [15:0]       errors_q, errors_d;
	logic [TW-1:0]     last_q, last_d;
	logic              have_q, have_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              full_q, full_d;
	logic [SUM_W-1:0]  sum_q, sum_d;

	logic              ring_we;
	logic [TW-1:0]     interval;
	logic [TW-1:0]     ring_rdata;
	logic              step_flag, err_flag, err_inc, edge_seen;

	logic              valid_s2;
	logic [2:0]        hall_s2;
	logic [31:0]       steps_s2;
	logic signed [1:0] dir_s2;
	logic [15:0]       errors_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic [HELD_W-1:0] held_s2;
	logic              step_s2, err_s2;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;
	assign interval = ts_s1 - last_q;

	hsd_ram #(
		.WIDTH(TW),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(idx_q),
		.wdata(interval),
		.raddr(idx_d),
		.rdata(ring_rdata)
	);

	always_comb begin
		hall_d    = hall_q;
		steps_d   = steps_q;
		dir_d     = dir_q;
		errors_d  = errors_q;
		last_d    = last_q;
		have_d    = have_q;
		idx_d     = idx_q;
		full_d    = full_q;
		sum_d     = sum_q;
		ring_we   = 1'b0;
		step_flag = 1'b0;
		err_flag  = 1'b0;
		err_inc   = 1'b0;
		edge_seen = 1'b0;
		if (fire) begin
			unique case (func_s1)
				hsd_pkg::FUNC_SAMPLE: begin
					if (hall_q == hsd_pkg::HALL_NONE) begin
						if (hsd_pkg::code_valid(code_s1)) begin
							hall_d = code_s1;
						end else if (code_s1 == hsd_pkg::HALL_INVALID) begin
							err_inc = 1'b1;
						end
					end else if (code_s1 != hall_q) begin
						edge_seen = 1'b1;
						if (!hsd_pkg::code_valid(code_s1)) begin
							err_inc = 1'b1;
						end else begin
							if (hsd_pkg::next_positive(hall_q) == code_s1) begin
								step_flag = 1'b1;
								dir_d     = hsd_pkg::DIR_POS;
							end else if (hsd_pkg::next_positive(code_s1) == hall_q) begin
								step_flag = 1'b1;
								dir_d     = hsd_pkg::DIR_NEG;
							end else begin
								err_inc = 1'b1;
							end
							hall_d = code_s1;
						end
					end
					if (step_flag) begin
						steps_d = steps_q + 32'd1;
					end
					if (err_inc) begin
						err_flag = 1'b1;
						if (errors_q != hsd_pkg::ERR_MAX) begin
							errors_d = errors_q + 16'd1;
						end
					end
					if (edge_seen) begin
						last_d = ts_s1;
						have_d = 1'b1;
						if (have_q) begin
							ring_we = 1'b1;
							sum_d   = sum_q + SUM_W'(interval)
							        - (full_q ? SUM_W'(ring_rdata) : '0);
							if (idx_q == IDX_W'(WINDOW - 1)) begin
								idx_d  = '0;
								full_d = 1'b1;
							end else begin
								idx_d = idx_q + IDX_W'(1);
							end
						end
					end
				end
				hsd_pkg::FUNC_ZERO_STEPS: begin
					steps_d = '0;
				end
				hsd_pkg::FUNC_CLEAR: begin
					steps_d  = '0;
					dir_d    = hsd_pkg::DIR_NONE;
					errors_d = '0;
					last_d   = '0;
					have_d   = 1'b0;
					idx_d    = '0;
					full_d   = 1'b0;
					sum_d    = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			hall_q   <= hsd_pkg::HALL_NONE;
			steps_q  <= '0;
			dir_q    <= hsd_pkg::DIR_NONE;
			errors_q <= '0;
			last_q   <= '0;
			have_q   <= 1'b0;
			idx_q    <= '0;
			full_q   <= 1'b0;
			sum_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			hall_q   <= hall_d;
			steps_q  <= steps_d;
			dir_q    <= dir_d;
			errors_q <= errors_d;
			last_q   <= last_d;
			have_q   <= have_d;
			idx_q    <= idx_d;
			full_q   <= full_d;
			sum_q    <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			code_s1 <= hall_code;
			ts_s1   <= timestamp;
		end
		if (fire) begin
			hall_s2   <= hall_d;
			steps_s2  <= steps_d;
			dir_s2    <= dir_d;
			errors_s2 <= errors_d;
			sum_s2    <= sum_d;
			held_s2   <= full_d ? HELD_W'(WINDOW) : HELD_W'(idx_d);
			step_s2   <= step_flag;
			err_s2    <= err_flag;
		end
	end

	assign out_valid      = valid_s2;
	assign active_code    = hall_s2;
	assign step_count     = steps_s2;
	assign direction      = dir_s2;
	assign error_count    = errors_s2;
	assign interval_sum   = sum_s2;
	assign intervals_held = held_s2;
	assign step_seen      = step_s2;
	assign error_seen     = err_s2;

endmodule
